// ===== design/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants
// Holds the axis codes, the width of the crossing fraction, the min_delta reset
// value and the pipeline control word that goes from cell to cell.
// ----------------------------------------------------------------------------
package spi_pkg;

   // axis codes carried on tuser
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // fractional bits of t; 1.0 is 2^T_FRAC
   localparam int T_FRAC = 32;

   localparam logic [15:0] MIN_DELTA_RESET = 16'd21;

   // control word that travels with each request
   typedef struct packed {
      logic valid;
      logic hit;
      logic one;   // t is exactly 1.0
   } ctrl_type;

endpackage

// ===== design/segment_axis_plane_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_axis_plane_intersect: segment crossing an axis-aligned plane
// Front stage, a row of division cells for t, and per-axis scaling.
// ----------------------------------------------------------------------------
// One request enters every cycle, and its result passes one front stage,
// 32 division cells and two scaling stages. t is found one bit per cell
// by restoring division, so the row of 32 cells sets the latency;
// throughput is one request per cycle. A stalled result holds the
// whole pipeline. min_delta may be written only while the block is idle.
module segment_axis_plane_intersect
   import spi_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [15:0]                           csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, plane_value, zero pad
   input  logic [((7*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   // req_type
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // point_x, point_y, point_z, zero pad
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // hit
   output logic                                  rsp_tuser
);

   localparam int CW     = COORD_WIDTH;
   localparam int W      = CW + 1;
   localparam int SIDE_W = 3*CW + 3*W;
   localparam int OUT_W  = ((3*CW+7)/8)*8;

   logic [15:0] min_delta_ff;
   logic        en;

   logic signed [CW-1:0] s [3];
   logic signed [CW-1:0] e [3];
   logic signed [W-1:0]  d [3];
   logic signed [CW-1:0] plane;
   logic signed [W-1:0]  d_ax;
   logic signed [CW-1:0] s_ax;
   logic signed [W-1:0]  num;
   logic [W-1:0]         ad, an;
   logic                 axis_ok, hit_in;

   ctrl_type          ctrl_in;
   ctrl_type          ctrl_w [33];
   logic [W-1:0]      rem_w  [33];
   logic [W-1:0]      den_w  [33];
   logic [T_FRAC-1:0] t_w    [33];
   logic [SIDE_W-1:0] side_w [33];
   logic [SIDE_W-1:0] side_in;

   ctrl_type             ctrl_s1_ff, ctrl_s2_ff;
   logic signed [CW-1:0] coord [3];

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_delta_ff <= MIN_DELTA_RESET;
      end else if (csr_wen) begin
         min_delta_ff <= csr_wdata;
      end
   end

   assign en         = !ctrl_s2_ff.valid || rsp_tready;
   assign req_tready = en;

   // unpack and select the plane axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s[i] = req_tdata[i*CW +: CW];
         e[i] = req_tdata[(i+3)*CW +: CW];
         d[i] = W'(e[i]) - W'(s[i]);
      end
      plane   = req_tdata[6*CW +: CW];
      axis_ok = 1'b1;
      case (req_tuser)
         AXIS_X: begin
            d_ax = d[0];
            s_ax = s[0];
         end
         AXIS_Y: begin
            d_ax = d[1];
            s_ax = s[1];
         end
         AXIS_Z: begin
            d_ax = d[2];
            s_ax = s[2];
         end
         default: begin
            d_ax    = d[0];
            s_ax    = s[0];
            axis_ok = 1'b0;
         end
      endcase
      num = W'(plane) - W'(s_ax);
      ad  = d_ax[W-1] ? W'(-d_ax) : W'(d_ax);
      an  = num[W-1] ? W'(-num) : W'(num);
      hit_in = axis_ok && (ad != '0) && (ad >= W'(min_delta_ff))
               && !((num != '0) && (num[W-1] != d_ax[W-1])) && (an <= ad);
      ctrl_in.valid = req_tvalid;
      ctrl_in.hit   = hit_in;
      ctrl_in.one   = (an == ad);
      side_in = {d[2], d[1], d[0], s[2], s[1], s[0]};
   end

   // front stage
   ctrl_type          ctrl_f_ff;
   logic [W-1:0]      an_ff, ad_ff;
   logic [SIDE_W-1:0] side_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_f_ff <= '0;
      end else if (en) begin
         ctrl_f_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         an_ff     <= an;
         ad_ff     <= ad;
         side_f_ff <= side_in;
      end
   end

   assign ctrl_w[0] = ctrl_f_ff;
   assign rem_w[0]  = an_ff;
   assign den_w[0]  = ad_ff;
   assign t_w[0]    = '0;
   assign side_w[0] = side_f_ff;

   // row of division cells, one quotient bit each
   for (genvar k = 0; k < T_FRAC; k++) begin : g_cell
      spi_div_cell #(.W(W), .SIDE_W(SIDE_W)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .ctrl_i (ctrl_w[k]),
         .rem_i  (rem_w[k]),
         .den_i  (den_w[k]),
         .t_i    (t_w[k]),
         .side_i (side_w[k]),
         .ctrl_o (ctrl_w[k+1]),
         .rem_o  (rem_w[k+1]),
         .den_o  (den_w[k+1]),
         .t_o    (t_w[k+1]),
         .side_o (side_w[k+1])
      );
   end

   // per-axis scaling
   for (genvar a = 0; a < 3; a++) begin : g_axis
      spi_scale #(.CW(CW)) u_scale (
         .clock   (clock),
         .en      (en),
         .start_i (side_w[T_FRAC][a*CW +: CW]),
         .delta_i (side_w[T_FRAC][3*CW + a*W +: W]),
         .t_i     (t_w[T_FRAC]),
         .one_i   (ctrl_w[T_FRAC].one),
         .coord_o (coord[a])
      );
   end

   // control alongside the scaling stages
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_s1_ff <= '0;
         ctrl_s2_ff <= '0;
      end else if (en) begin
         ctrl_s1_ff <= ctrl_w[T_FRAC];
         ctrl_s2_ff <= ctrl_s1_ff;
      end
   end

   // result, zero point on a miss
   assign rsp_tvalid = ctrl_s2_ff.valid;
   assign rsp_tuser  = ctrl_s2_ff.hit;
   assign rsp_tdata  = ctrl_s2_ff.hit ? OUT_W'({coord[2], coord[1], coord[0]}) : '0;

endmodule

// ===== design/spi_div_cell.sv =====
// ----------------------------------------------------------------------------
// spi_div_cell: one restoring division step
// Shifts the partial remainder, tries to subtract the divisor and shifts one
// quotient bit into t. Side data rides along unchanged.
// ----------------------------------------------------------------------------
module spi_div_cell
   import spi_pkg::*;
#(
   parameter int W      = 33,
   parameter int SIDE_W = 195
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  ctrl_type          ctrl_i,
   input  logic [W-1:0]      rem_i,
   input  logic [W-1:0]      den_i,
   input  logic [T_FRAC-1:0] t_i,
   input  logic [SIDE_W-1:0] side_i,
   output ctrl_type          ctrl_o,
   output logic [W-1:0]      rem_o,
   output logic [W-1:0]      den_o,
   output logic [T_FRAC-1:0] t_o,
   output logic [SIDE_W-1:0] side_o
);

   ctrl_type          ctrl_ff;
   logic [W-1:0]      rem_ff, rem_in;
   logic [W-1:0]      den_ff;
   logic [T_FRAC-1:0] t_ff, t_in;
   logic [SIDE_W-1:0] side_ff;
   logic [W:0]        rem2;
   logic [W:0]        diff;

   // trial subtract
   always_comb begin
      rem2 = {rem_i, 1'b0};
      diff = rem2 - {1'b0, den_i};
      if (rem2 >= {1'b0, den_i}) begin
         rem_in = diff[W-1:0];
         t_in   = {t_i[T_FRAC-2:0], 1'b1};
      end else begin
         rem_in = rem2[W-1:0];
         t_in   = {t_i[T_FRAC-2:0], 1'b0};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_i;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         den_ff  <= den_i;
         t_ff    <= t_in;
         side_ff <= side_i;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign rem_o  = rem_ff;
   assign den_o  = den_ff;
   assign t_o    = t_ff;
   assign side_o = side_ff;

endmodule

// ===== design/spi_scale.sv =====
// ----------------------------------------------------------------------------
// spi_scale: start + floor(delta * t) for one axis
// Two stages: partial products, then sum, floor correction and offset.
// ----------------------------------------------------------------------------
module spi_scale
   import spi_pkg::*;
#(
   parameter int CW = 32
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] start_i,
   input  logic signed [CW:0]   delta_i,
   input  logic [T_FRAC-1:0]    t_i,
   input  logic                 one_i,
   output logic signed [CW-1:0] coord_o
);

   localparam int W  = CW + 1;
   localparam int AW = (W > 32) ? W : 33;
   localparam int HW = AW - 32;

   logic [W-1:0]         mag;
   logic [AW-1:0]        mag_ext;
   logic                 neg_ff;
   logic                 one_ff;
   logic [AW-1:0]        mag_ff;
   logic signed [CW-1:0] start_ff;
   logic [63:0]          plo_ff;
   logic [HW+31:0]       phi_ff;
   logic [AW:0]          q;
   logic                 rem;
   logic [AW:0]          sum;
   logic signed [CW-1:0] coord_ff, coord_in;

   always_comb begin
      mag     = delta_i[CW] ? W'(-delta_i) : W'(delta_i);
      mag_ext = AW'(mag);
   end

   // partial products
   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff   <= delta_i[CW];
         one_ff   <= one_i;
         mag_ff   <= mag_ext;
         start_ff <= start_i;
         plo_ff   <= mag_ext[31:0] * t_i;
         phi_ff   <= mag_ext[AW-1:32] * t_i;
      end
   end

   // sum, round towards minus infinity, add start
   always_comb begin
      if (one_ff) begin
         q   = (AW+1)'(mag_ff);
         rem = 1'b0;
      end else begin
         q   = (AW+1)'(phi_ff) + (AW+1)'(plo_ff[63:32]);
         rem = |plo_ff[31:0];
      end
      if (neg_ff) begin
         sum = (AW+1)'(start_ff) - q - (AW+1)'(rem);
      end else begin
         sum = (AW+1)'(start_ff) + q;
      end
      coord_in = sum[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff <= coord_in;
      end
   end

   assign coord_o = coord_ff;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: segment_axis_plane_intersect
// Drives segment requests over the stream input, predicts the crossing point
// per request and checks each response in order. Walks a directed table of
// edge cases, then random segments, across several min_delta settings and
// three idling patterns.
// ----------------------------------------------------------------------------
module testbench
   import spi_pkg::*;
();

   localparam int CW = 32;
   localparam int LATENCY = 35;

   typedef struct packed {
      logic          hit;
      logic [CW-1:0] px, py, pz;
   } crossing_type;

   typedef struct {
      logic [1:0]    axis;
      logic [CW-1:0] s [3];
      logic [CW-1:0] e [3];
      logic [CW-1:0] plane;
      logic          chk;   // typed-in expectation present
      crossing_type  want;
   } segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wen = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7*CW-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [3*CW-1:0] rsp_tdata;
   logic rsp_tuser;

   logic [15:0]  min_delta_q = MIN_DELTA_RESET;
   crossing_type pending_q [$];
   int           error_count = 0;
   int           hit_count = 0;
   int           request_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   segment_type  table_q [$];

   segment_axis_plane_intersect #(.COORD_WIDTH(CW)) dut (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   initial begin
      #40ms;
      $display("FAIL segment_axis_plane_intersect");
      $finish;
   end

   // floor(d * t / 2^32) with t up to 2^32
   function automatic longint scale_delta(longint d, logic [32:0] t);
      logic [127:0] p;
      logic [63:0]  a;
      a = (d < 0) ? -d : d;
      p = a * t;
      if (d < 0) return -longint'(p[95:32] + (p[31:0] != 0));
      return longint'(p[95:32]);
   endfunction

   function automatic crossing_type predict_crossing(segment_type x);
      crossing_type r;
      longint       s [3], dl [3], num;
      logic [63:0]  ad, an, rem;
      logic [32:0]  t;
      r = '{1'b0, '0, '0, '0};
      for (int i = 0; i < 3; i++) begin
         s[i] = longint'(signed'(x.s[i]));
         dl[i] = longint'(signed'(x.e[i])) - s[i];
      end
      if (x.axis > AXIS_Z) return r;
      ad = (dl[x.axis] < 0) ? -dl[x.axis] : dl[x.axis];
      if (ad == 0 || ad < min_delta_q) return r;
      num = longint'(signed'(x.plane)) - s[x.axis];
      an = (num < 0) ? -num : num;
      if (num != 0 && ((num < 0) != (dl[x.axis] < 0))) return r;
      if (an > ad) return r;
      if (an == ad) t = 33'h1_0000_0000;
      else begin
         t = '0;
         rem = an;
         for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            t = t << 1;
            if (rem >= ad) begin
               rem -= ad;
               t[0] = 1'b1;
            end
         end
      end
      r.hit = 1'b1;
      r.px = CW'(s[0] + scale_delta(dl[0], t));
      r.py = CW'(s[1] + scale_delta(dl[1], t));
      r.pz = CW'(s[2] + scale_delta(dl[2], t));
      return r;
   endfunction

   task automatic report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      crossing_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            report("unexpected response", rsp_tdata[CW-1:0], '0);
         end else begin
            w = pending_q.pop_front();
            if (rsp_tuser !== w.hit) report("hit", CW'(rsp_tuser), CW'(w.hit));
            if (rsp_tdata[CW-1:0] !== w.px) report("point_x", rsp_tdata[CW-1:0], w.px);
            if (rsp_tdata[2*CW-1:CW] !== w.py)
               report("point_y", rsp_tdata[2*CW-1:CW], w.py);
            if (rsp_tdata[3*CW-1:2*CW] !== w.pz)
               report("point_z", rsp_tdata[3*CW-1:2*CW], w.pz);
            hit_count += w.hit;
         end
      end
   end

   // receiver stalls
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // valid stays up after acceptance until the next request or a drain
   task automatic send_request(segment_type x);
      crossing_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= x.axis;
      req_tdata <= {x.plane, x.e[2], x.e[1], x.e[0], x.s[2], x.s[1], x.s[0]};
      do @(posedge clock); while (!req_tready);
      p = predict_crossing(x);
      if (x.chk && p != x.want) report("table row", p.px, x.want.px);
      pending_q = {pending_q, (x.chk ? x.want : p)};
      request_count++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_min_delta(logic [15:0] v);
      drain();
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen <= 1'b0;
      min_delta_q = v;
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return CW'($signed($urandom_range(2_000_000)) - 1_000_000);
         2: return {CW{1'($urandom_range(1))}} ^ CW'($urandom_range(255));
         default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
   endfunction

   // random segment; mostly a plane that lies on the segment
   function automatic segment_type rand_segment();
      segment_type x;
      longint      a, b;
      x.axis = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      for (int i = 0; i < 3; i++) begin
         x.s[i] = rand_coord();
         x.e[i] = rand_coord();
      end
      if ($urandom_range(9) < 8 && x.axis <= AXIS_Z) begin
         a = longint'(signed'(x.s[x.axis]));
         b = longint'(signed'(x.e[x.axis]));
         x.plane = CW'(a + (((b - a) * longint'($urandom_range(1000))) / 1000));
      end else x.plane = rand_coord();
      x.chk = 1'b0;
      return x;
   endfunction

   function automatic segment_type row(logic [1:0] ax, logic [CW-1:0] s0, logic [CW-1:0] e0,
                                       logic [CW-1:0] pl, logic chk, crossing_type w);
      segment_type x;
      x.axis = ax;
      x.s = '{s0, 32'h0001_0000, 32'hffff_0000};
      x.e = '{e0, 32'h0003_0000, 32'h0001_0000};
      x.s[ax == 2'd3 ? 0 : ax] = s0;
      x.e[ax == 2'd3 ? 0 : ax] = e0;
      x.plane = pl;
      x.chk = chk;
      x.want = w;
      return x;
   endfunction

   // append one row to the directed table
   task automatic add_row(segment_type x);
      table_q = {table_q, x};
   endtask

   localparam crossing_type MISS = '{1'b0, '0, '0, '0};

   initial begin
      segment_type x;
      // directed table: edge cases on each axis
      add_row(row(2'd3, 0, 32'h0010_0000, 32'h8_0000, 1, MISS)); // unused axis
      add_row(row(AXIS_X, 5, 5, 5, 1, MISS));                    // zero delta
      add_row(row(AXIS_Y, 0, 20, 10, 1, MISS));                  // below min_delta
      add_row(row(AXIS_Z, 0, 100, -1, 1, MISS));                 // behind start
      add_row(row(AXIS_X, 0, 100, 101, 1, MISS));                // past end
      add_row(row(AXIS_X, 0, 100, 0, 0, MISS));                  // plane at start
      add_row(row(AXIS_Y, 0, 100, 100, 0, MISS));                // exact end
      add_row(row(AXIS_Z, 100, 0, 100, 0, MISS));
      add_row(row(AXIS_Z, 100, 0, 0, 0, MISS));
      add_row(row(AXIS_X, 32'h8000_0000, 32'h7fff_ffff, 0, 0, MISS));
      add_row(row(AXIS_Y, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, MISS));
      add_row(row(AXIS_Z, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0, MISS));
      add_row(row(AXIS_X, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, MISS));
      add_row(row(AXIS_Y, 0, 3, 1, 0, MISS));
      add_row(row(AXIS_X, 32'hffff_0000, 32'h0001_0000, 32'h0000_8000, 0, MISS));
      for (int i = 0; i < table_q.size(); i++) begin
         x = table_q[i];
         x.s[1] = 32'hffff_ffff; x.e[2] = 32'h8000_0000;
         x.s[2] = 32'h7fff_ffff; x.e[1] = 32'h0;
         x.s[x.axis == 2'd3 ? 0 : x.axis] = table_q[i].s[x.axis == 2'd3 ? 0 : x.axis];
         x.e[x.axis == 2'd3 ? 0 : x.axis] = table_q[i].e[x.axis == 2'd3 ? 0 : x.axis];
         table_q[i] = x;
      end

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (table_q[i]) send_request(table_q[i]);

      // random phases across register settings and idling patterns
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_min_delta(16'd0);
            1: write_min_delta(16'hffff);
            2: write_min_delta(16'd1);
            3: write_min_delta(16'($urandom()));
            4: write_min_delta(MIN_DELTA_RESET);
            default: write_min_delta(16'd3);
         endcase
         send_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 55 : 0;
         recv_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 7 : 0;
         for (int n = 0; n < 125; n++) begin
            if (ph == 3 && n == 60) drain();   // hold off until all responses are in
            send_request(rand_segment());
         end
      end

      drain();
      $display("covered %0d requests, %0d crossings, six min_delta settings",
               request_count, hit_count);
      if (error_count == 0 && pending_q.size() == 0)
         $display("PASS segment_axis_plane_intersect");
      else
         $display("FAIL segment_axis_plane_intersect");
      $finish;
   end

endmodule
